### design/proportional_clock_group_advance_macros.svh
// Assertion macros used by the clock group advance RTL.
`ifndef PROPORTIONAL_CLOCK_GROUP_ADVANCE_MACROS_SVH
`define PROPORTIONAL_CLOCK_GROUP_ADVANCE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PCGA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pcga assertion failed");

// Next-cycle implication, disabled during reset.
`define PCGA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pcga assertion failed");

`endif

### design/pcga_pkg.sv
// Package: types and constants of the clock group advance block.
`timescale 1ns / 1ps
`default_nettype none
package pcga_pkg;

   localparam int NUM_CLOCKS = 4;
   localparam int SLOT_W     = $clog2(NUM_CLOCKS);
   localparam int COUNT_W    = 3;
   localparam int TICK_W     = 64;
   localparam int RATE_W     = 32;
   localparam int CNT_W      = 16;
   localparam int PROD_W     = CNT_W + RATE_W;
   localparam int STEP_W     = $clog2(PROD_W + 1);
   localparam int CSR_IDX_W  = 3;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_CLOCK_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_0      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_1      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_2      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_3      = 3'd4;

   // item opcodes
   localparam logic OP_ADVANCE = 1'b0;
   localparam logic OP_RESET   = 1'b1;

   typedef struct packed {
      logic             op;
      logic [1:0]       source_index;
      logic [CNT_W-1:0] tick_count;
   } req_type;

   typedef struct packed {
      logic [1:0]        clock_index;
      logic [TICK_W-1:0] tick_value;
      logic [RATE_W-1:0] remainder;
      logic              last;
   } rsp_type;

endpackage
`default_nettype wire

### design/pcga_divider.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module pcga_divider (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [pcga_pkg::PROD_W-1:0] dividend,
   input  wire logic [pcga_pkg::RATE_W-1:0] divisor,
   output logic                             done,
   output logic [pcga_pkg::PROD_W-1:0]      quotient,
   output logic [pcga_pkg::RATE_W-1:0]      remainder
);
   import pcga_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [PROD_W-1:0] quo_ff, quo_in;
   logic [RATE_W-1:0] rem_ff, rem_in;
   logic [RATE_W-1:0] dvs_ff, dvs_in;
   logic [RATE_W:0]   shifted;
   logic [RATE_W:0]   diff;
   logic              fits;

   assign shifted = {rem_ff, quo_ff[PROD_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign fits    = shifted >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(PROD_W);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[RATE_W-1:0] : shifted[RATE_W-1:0];
         quo_in  = {quo_ff[PROD_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

### design/proportional_clock_group_advance.sv
// Top level: clock group tick accumulator with a shared serial divider.
// Advance item: accepted, then for each other active clock a multiply, a divider start,
//   48 divide steps in the one-bit-per-cycle divider, and an update.
// Results follow at one per cycle while rsp_ready is high.
// Reset item or inactive source: goes straight to emitting results. One item at a time.
// Reset: synchronous, active high; clock_count and rates to 1, ticks and remainders to 0.
`timescale 1ns / 1ps
`default_nettype none
`include "proportional_clock_group_advance_macros.svh"
module proportional_clock_group_advance (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire pcga_pkg::req_type              req_payload,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output pcga_pkg::rsp_type                   rsp_payload,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [pcga_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [pcga_pkg::RATE_W-1:0]    csr_data
);
   import pcga_pkg::*;

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SEL   = 3'd1;  // pick next slot, skip the source
   localparam logic [2:0] ST_MUL   = 3'd2;  // rem + cnt * rate
   localparam logic [2:0] ST_START = 3'd3;  // launch divider
   localparam logic [2:0] ST_WAIT  = 3'd4;  // wait for quotient, update slot
   localparam logic [2:0] ST_EMIT  = 3'd5;  // one result transfer per active slot

   logic [2:0]         state_ff, state_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [SLOT_W-1:0]  src_ff, src_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [RATE_W-1:0]  rate_ff  [NUM_CLOCKS];
   logic [RATE_W-1:0]  rate_in  [NUM_CLOCKS];
   logic [TICK_W-1:0]  ticks_ff [NUM_CLOCKS];
   logic [TICK_W-1:0]  ticks_in [NUM_CLOCKS];
   logic [RATE_W-1:0]  rem_ff   [NUM_CLOCKS];
   logic [RATE_W-1:0]  rem_in   [NUM_CLOCKS];

   logic [COUNT_W-1:0] act_n;
   logic               slot_last;
   logic               req_xfer;
   logic               div_start;
   logic               div_done;
   logic [PROD_W-1:0]  div_quo;
   logic [RATE_W-1:0]  div_rem;
   logic [RATE_W-1:0]  csr_rate;

   // active count: 0 acts as 1, saturate at NUM_CLOCKS
   always_comb begin
      if (count_ff == '0) begin
         act_n = COUNT_W'(1);
      end else if (count_ff > COUNT_W'(NUM_CLOCKS)) begin
         act_n = COUNT_W'(NUM_CLOCKS);
      end else begin
         act_n = count_ff;
      end
   end

   assign slot_last = ({1'b0, slot_ff} + COUNT_W'(1)) == act_n;
   assign req_ready = state_ff == ST_IDLE;
   assign req_xfer  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign csr_rate  = (csr_data == '0) ? RATE_W'(1) : csr_data;

   // shared divider: dividend is the registered product, divisor the source rate
   pcga_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (prod_ff),
      .divisor   (rate_ff[src_ff]),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      state_in  = state_ff;
      slot_in   = slot_ff;
      src_in    = src_ff;
      cnt_in    = cnt_ff;
      prod_in   = prod_ff;
      count_in  = count_ff;
      rate_in   = rate_ff;
      ticks_in  = ticks_ff;
      rem_in    = rem_ff;
      div_start = 1'b0;

      // config transfers must arrive only while idle; the block itself does not enforce it
      if (csr_valid) begin
         case (csr_index)
            CSR_CLOCK_COUNT: count_in   = csr_data[COUNT_W-1:0];
            CSR_RATE_0:      rate_in[0] = csr_rate;
            CSR_RATE_1:      rate_in[1] = csr_rate;
            CSR_RATE_2:      rate_in[2] = csr_rate;
            CSR_RATE_3:      rate_in[3] = csr_rate;
            default:         ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               cnt_in  = req_payload.tick_count;
               src_in  = req_payload.source_index;
               slot_in = '0;
               if (req_payload.op == OP_RESET) begin
                  // every slot, active or not
                  for (int i = 0; i < NUM_CLOCKS; i++) begin
                     ticks_in[i] = '0;
                     rem_in[i]   = rate_ff[i] >> 1;
                  end
                  state_in = ST_EMIT;
               end else if ({1'b0, req_payload.source_index} < act_n) begin
                  ticks_in[req_payload.source_index] =
                     ticks_ff[req_payload.source_index] + TICK_W'(req_payload.tick_count);
                  state_in = ST_SEL;
               end else begin
                  // inactive source: state untouched, still report
                  state_in = ST_EMIT;
               end
            end
         end
         ST_SEL: begin
            if (slot_ff == src_ff) begin
               if (slot_last) begin
                  slot_in  = '0;
                  state_in = ST_EMIT;
               end else begin
                  slot_in = slot_ff + SLOT_W'(1);
               end
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // 16x32 product plus 32-bit remainder stays below 2^48
            prod_in  = PROD_W'(cnt_ff) * PROD_W'(rate_ff[slot_ff])
                     + PROD_W'(rem_ff[slot_ff]);
            state_in = ST_START;
         end
         ST_START: begin
            div_start = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_done) begin
               ticks_in[slot_ff] = ticks_ff[slot_ff] + TICK_W'(div_quo);
               rem_in[slot_ff]   = div_rem;
               if (slot_last) begin
                  slot_in  = '0;
                  state_in = ST_EMIT;
               end else begin
                  slot_in  = slot_ff + SLOT_W'(1);
                  state_in = ST_SEL;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               if (slot_last) begin
                  slot_in  = '0;
                  state_in = ST_IDLE;
               end else begin
                  slot_in = slot_ff + SLOT_W'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         slot_ff  <= '0;
         count_ff <= COUNT_W'(1);
         for (int i = 0; i < NUM_CLOCKS; i++) begin
            rate_ff[i]  <= RATE_W'(1);
            ticks_ff[i] <= '0;
            rem_ff[i]   <= '0;
         end
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
         count_ff <= count_in;
         rate_ff  <= rate_in;
         ticks_ff <= ticks_in;
         rem_ff   <= rem_in;
      end
      src_ff  <= src_in;
      cnt_ff  <= cnt_in;
      prod_ff <= prod_in;
   end

   // results read straight from slot state, which holds still while emitting
   assign rsp_valid               = state_ff == ST_EMIT;
   assign rsp_payload.clock_index = 2'(slot_ff);
   assign rsp_payload.tick_value  = ticks_ff[slot_ff];
   assign rsp_payload.remainder   = rem_ff[slot_ff];
   assign rsp_payload.last        = slot_last;

   `PCGA_ASSERT_NOW(a_no_overlap, clock, reset, rsp_valid, !req_ready)
   `PCGA_ASSERT_NEXT(a_reset_item_reports, clock, reset,
      req_xfer && req_payload.op == OP_RESET, rsp_valid && slot_ff == '0)
   `PCGA_ASSERT_NEXT(a_last_frees, clock, reset,
      rsp_valid && rsp_ready && rsp_payload.last, req_ready)
   `PCGA_ASSERT_NEXT(a_div_update_moves_on, clock, reset,
      state_ff == ST_WAIT && div_done, state_ff == ST_SEL || state_ff == ST_EMIT)

endmodule
`default_nettype wire
